[src/cmtt_pkg.sv]
// ----------------------------------------------------------------------------
// cmtt_pkg
// types, register codes and constants shared by the cube motion tap tracker
// ----------------------------------------------------------------------------
`default_nettype none

package cmtt_pkg;

    localparam int ADDR_W = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] CFG_START_MOVING = 3'd0;
    localparam logic [REG_IDX_W-1:0] CFG_STOP_MOVING  = 3'd1;
    localparam logic [REG_IDX_W-1:0] CFG_MOVE_THRESH  = 3'd2;
    localparam logic [REG_IDX_W-1:0] CFG_UP_STABLE    = 3'd3;
    localparam logic [REG_IDX_W-1:0] CFG_FILT_WEIGHT  = 3'd4;
    localparam logic [REG_IDX_W-1:0] CFG_MAX_TAP      = 3'd5;

    localparam logic [7:0] START_MOVING_RST = 8'd2;
    localparam logic [7:0] STOP_MOVING_RST  = 8'd5;
    localparam logic [7:0] MOVE_THRESH_RST  = 8'd5;
    localparam logic [7:0] UP_STABLE_RST    = 8'd15;
    localparam logic [6:0] FILT_WEIGHT_RST  = 7'd20;
    localparam logic [7:0] MAX_TAP_RST      = 8'd8;

    localparam logic [6:0] WEIGHT_FULL = 7'd100;

    // divide by 100 as multiply by reciprocal, exact for magnitudes below 43690
    localparam int DIV_MAG_W = 14;
    localparam int DIV_RECIP_W = 13;
    localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 13'd5243;
    localparam int DIV_SHIFT = 19;

    localparam logic [2:0] AXIS_UNKNOWN = 3'd6;

    typedef enum logic [1:0] {
        KIND_TAPPED   = 2'd0,
        KIND_UP_AXIS  = 2'd1,
        KIND_MOVED    = 2'd2,
        KIND_STOPPED  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0]        last_shock;
        logic signed [7:0] filt_x;
        logic signed [7:0] filt_y;
        logic signed [7:0] filt_z;
        logic [7:0]        motion_cnt;
        logic              moving;
        logic [2:0]        prev_axis;
        logic [2:0]        rep_axis;
        logic [2:0]        cand_axis;
        logic [7:0]        cand_cnt;
    } state_t;

    localparam state_t STATE_RESET = '{
        last_shock: 8'd0,
        filt_x:     8'sd0,
        filt_y:     8'sd0,
        filt_z:     8'sd0,
        motion_cnt: 8'd0,
        moving:     1'b0,
        prev_axis:  AXIS_UNKNOWN,
        rep_axis:   AXIS_UNKNOWN,
        cand_axis:  AXIS_UNKNOWN,
        cand_cnt:   8'd0
    };

    typedef struct packed {
        logic [7:0]        cube_index;
        logic signed [7:0] accel_x;
        logic signed [7:0] accel_y;
        logic signed [7:0] accel_z;
        logic [7:0]        shock_total;
        logic [7:0]        tap_duration;
        logic signed [7:0] tap_negative;
        logic signed [7:0] tap_positive;
        logic [31:0]       time_ms;
    } item_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        cube_out;
        logic [31:0]       stamp_ms;
        logic [7:0]        tap_count;
        logic [7:0]        tap_duration_out;
        logic signed [7:0] tap_negative_out;
        logic signed [7:0] tap_positive_out;
        logic [2:0]        axis;
        logic signed [7:0] moved_x;
        logic signed [7:0] moved_y;
        logic signed [7:0] moved_z;
        logic              last;
    } result_t;

    function automatic result_t base_result(kind_t kind, item_t it);
        result_t r;
        r = '0;
        r.kind = kind;
        r.cube_out = it.cube_index;
        r.stamp_ms = it.time_ms;
        r.axis = AXIS_UNKNOWN;
        return r;
    endfunction

endpackage

`default_nettype wire

[src/cmtt_report_if.sv]
// ----------------------------------------------------------------------------
// cmtt_report_if
// request channel carrying one accelerometer report per cube
// ----------------------------------------------------------------------------
`default_nettype none

interface cmtt_report_if;
    logic              valid;
    logic              ready;
    logic [7:0]        cube_index;
    logic signed [7:0] accel_x;
    logic signed [7:0] accel_y;
    logic signed [7:0] accel_z;
    logic [7:0]        shock_total;
    logic [7:0]        tap_duration;
    logic signed [7:0] tap_negative;
    logic signed [7:0] tap_positive;
    logic [31:0]       time_ms;

    modport source (
        output valid, cube_index, accel_x, accel_y, accel_z, shock_total,
        output tap_duration, tap_negative, tap_positive, time_ms,
        input  ready
    );

    modport sink (
        input  valid, cube_index, accel_x, accel_y, accel_z, shock_total,
        input  tap_duration, tap_negative, tap_positive, time_ms,
        output ready
    );
endinterface

`default_nettype wire

[src/cmtt_result_if.sv]
// ----------------------------------------------------------------------------
// cmtt_result_if
// request channel carrying tap, up axis, moved and stopped results
// ----------------------------------------------------------------------------
`default_nettype none

interface cmtt_result_if;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [7:0]        cube_out;
    logic [31:0]       stamp_ms;
    logic [7:0]        tap_count;
    logic [7:0]        tap_duration_out;
    logic signed [7:0] tap_negative_out;
    logic signed [7:0] tap_positive_out;
    logic [2:0]        axis;
    logic signed [7:0] moved_x;
    logic signed [7:0] moved_y;
    logic signed [7:0] moved_z;
    logic              last;

    modport source (
        output valid, kind, cube_out, stamp_ms, tap_count, tap_duration_out,
        output tap_negative_out, tap_positive_out, axis, moved_x, moved_y, moved_z,
        output last,
        input  ready
    );

    modport sink (
        input  valid, kind, cube_out, stamp_ms, tap_count, tap_duration_out,
        input  tap_negative_out, tap_positive_out, axis, moved_x, moved_y, moved_z,
        input  last,
        output ready
    );
endinterface

`default_nettype wire

[src/cmtt_filter.sv]
// ----------------------------------------------------------------------------
// cmtt_filter
// two-stage iir filter for one axis: weighted sum, then truncating divide by 100
// ----------------------------------------------------------------------------
`default_nettype none

module cmtt_filter (
    input  logic              clk,
    input  logic              adv,
    input  logic [6:0]        weight,
    input  logic signed [7:0] sample,
    input  logic signed [7:0] prev,
    output logic signed [7:0] filtered
);

    localparam int PROD_W = cmtt_pkg::DIV_MAG_W + cmtt_pkg::DIV_RECIP_W;

    logic signed [7:0]  w_new;
    logic signed [7:0]  w_old;
    logic signed [15:0] prod_new;
    logic signed [15:0] prod_old;
    logic signed [15:0] sum_next;
    logic signed [15:0] sum_reg;
    logic [15:0]        mag_full;
    logic [cmtt_pkg::DIV_MAG_W-1:0] mag;
    logic [PROD_W-1:0]  quot_prod;
    logic [7:0]         quot;
    logic signed [7:0]  filt_next;
    logic signed [7:0]  filt_reg;

    assign w_new    = signed'({1'b0, weight});
    assign w_old    = signed'({1'b0, 7'(cmtt_pkg::WEIGHT_FULL - weight)});
    assign prod_new = w_new * sample;
    assign prod_old = w_old * prev;
    assign sum_next = prod_new + prod_old;

    assign mag_full  = sum_reg[15] ? 16'(-sum_reg) : 16'(sum_reg);
    assign mag       = mag_full[cmtt_pkg::DIV_MAG_W-1:0];
    assign quot_prod = PROD_W'(mag) * PROD_W'(cmtt_pkg::DIV_RECIP);
    assign quot      = quot_prod[PROD_W-1:cmtt_pkg::DIV_SHIFT];
    assign filt_next = sum_reg[15] ? signed'(8'(-quot)) : signed'(quot);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg  <= sum_next;
            filt_reg <= filt_next;
        end
    end

    assign filtered = filt_reg;

endmodule

`default_nettype wire

[src/cube_motion_tap_tracker.sv]
// ----------------------------------------------------------------------------
// cube_motion_tap_tracker
// per-cube tap, up axis and motion tracking over a state memory
// ----------------------------------------------------------------------------
//  channel   role    handshake       carries
//  report    sink    valid / ready   one accelerometer report of one cube
//  result    source  valid / ready   tapped, up axis, moved, stopped results
//  apb       slave   psel / penable  six configuration registers
//
//  a report passes read, weighted sum, divide, compare and write-back stages;
//  its results leave the result buffer one result per cycle while result
//  ready is high. reports for different cubes enter every cycle while the
//  pipeline advances; a report for a cube still in the pipeline waits until
//  its write-back. the three-entry result buffer sets the pace: an item with
//  results waits in write-back until the buffer holds none, or one being popped.
//  reset clears per-cube valid bits, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cube_motion_tap_tracker #(
    parameter int NUM_CUBES = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cmtt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    cmtt_report_if.sink                 report,
    cmtt_result_if.source               result
);

    localparam int IDX_W = (NUM_CUBES > 1) ? $clog2(NUM_CUBES) : 1;
    localparam logic [8:0] CUBE_LIMIT = 9'(NUM_CUBES);

    // configuration registers
    logic [7:0] start_reg;
    logic [7:0] stop_reg;
    logic [7:0] thresh_reg;
    logic [7:0] stable_reg;
    logic [6:0] weight_reg;
    logic [7:0] max_tap_reg;
    logic       cfg_wr;
    logic [cmtt_pkg::REG_IDX_W-1:0] cfg_idx;
    logic [6:0] weight_eff;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[cmtt_pkg::ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= cmtt_pkg::START_MOVING_RST;
            stop_reg    <= cmtt_pkg::STOP_MOVING_RST;
            thresh_reg  <= cmtt_pkg::MOVE_THRESH_RST;
            stable_reg  <= cmtt_pkg::UP_STABLE_RST;
            weight_reg  <= cmtt_pkg::FILT_WEIGHT_RST;
            max_tap_reg <= cmtt_pkg::MAX_TAP_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                cmtt_pkg::CFG_START_MOVING: start_reg   <= pwdata[7:0];
                cmtt_pkg::CFG_STOP_MOVING:  stop_reg    <= pwdata[7:0];
                cmtt_pkg::CFG_MOVE_THRESH:  thresh_reg  <= pwdata[7:0];
                cmtt_pkg::CFG_UP_STABLE:    stable_reg  <= pwdata[7:0];
                cmtt_pkg::CFG_FILT_WEIGHT:  weight_reg  <= pwdata[6:0];
                cmtt_pkg::CFG_MAX_TAP:      max_tap_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            cmtt_pkg::CFG_START_MOVING: prdata = {24'd0, start_reg};
            cmtt_pkg::CFG_STOP_MOVING:  prdata = {24'd0, stop_reg};
            cmtt_pkg::CFG_MOVE_THRESH:  prdata = {24'd0, thresh_reg};
            cmtt_pkg::CFG_UP_STABLE:    prdata = {24'd0, stable_reg};
            cmtt_pkg::CFG_FILT_WEIGHT:  prdata = {25'd0, weight_reg};
            cmtt_pkg::CFG_MAX_TAP:      prdata = {24'd0, max_tap_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    assign weight_eff = (weight_reg > cmtt_pkg::WEIGHT_FULL) ? cmtt_pkg::WEIGHT_FULL
                                                             : weight_reg;

    // pipeline control
    logic             advance;
    logic             hazard;
    logic             fire;
    logic             in_range;
    logic [IDX_W-1:0] in_idx;
    cmtt_pkg::item_t  in_item;

    logic             s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    cmtt_pkg::item_t  s1_item_reg, s2_item_reg, s3_item_reg, s4_item_reg;
    cmtt_pkg::state_t s2_state_reg, s3_state_reg, s4_state_reg;
    logic [7:0]       s2_count_reg, s3_count_reg, s4_count_reg;
    logic             s2_bogus_reg, s3_bogus_reg, s4_bogus_reg;
    logic signed [7:0] s4_filt_reg [3];
    logic             s4_moving_now_reg;
    logic [2:0]       s4_dir_reg;

    // state memory
    cmtt_pkg::state_t state_mem [NUM_CUBES];
    cmtt_pkg::state_t rd_reg;
    logic [NUM_CUBES-1:0] valid_reg;
    logic             mem_wr;
    cmtt_pkg::state_t wb_state;
    logic [IDX_W-1:0] s1_idx;
    logic [IDX_W-1:0] s4_idx;

    assign in_item.cube_index   = report.cube_index;
    assign in_item.accel_x      = report.accel_x;
    assign in_item.accel_y      = report.accel_y;
    assign in_item.accel_z      = report.accel_z;
    assign in_item.shock_total  = report.shock_total;
    assign in_item.tap_duration = report.tap_duration;
    assign in_item.tap_negative = report.tap_negative;
    assign in_item.tap_positive = report.tap_positive;
    assign in_item.time_ms      = report.time_ms;

    assign in_range = {1'b0, report.cube_index} < CUBE_LIMIT;
    assign in_idx   = report.cube_index[IDX_W-1:0];
    assign s1_idx   = s1_item_reg.cube_index[IDX_W-1:0];
    assign s4_idx   = s4_item_reg.cube_index[IDX_W-1:0];

    // interlock: at most one report per cube in flight at a time
    assign hazard = (s1_v_reg && s1_item_reg.cube_index == report.cube_index) ||
                    (s2_v_reg && s2_item_reg.cube_index == report.cube_index) ||
                    (s3_v_reg && s3_item_reg.cube_index == report.cube_index) ||
                    (s4_v_reg && s4_item_reg.cube_index == report.cube_index);

    assign report.ready = advance && !hazard;
    assign fire         = report.valid && report.ready;
    assign mem_wr       = advance && s4_v_reg;

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            state_mem[s4_idx] <= wb_state;
        end
        if (fire && in_range)
        begin
            rd_reg <= state_mem[in_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (mem_wr)
        begin
            valid_reg[s4_idx] <= 1'b1;
        end
    end

    // stage 1: state lookup, shock delta, filter sums
    cmtt_pkg::state_t  s1_old;
    logic [7:0]        s1_delta;
    logic              s1_bogus;
    logic signed [7:0] s1_accel [3];
    logic signed [7:0] s1_prev [3];
    logic signed [7:0] s3_filt [3];
    logic signed [7:0] s3_accel [3];

    assign s1_old   = valid_reg[s1_idx] ? rd_reg : cmtt_pkg::STATE_RESET;
    assign s1_delta = s1_item_reg.shock_total - s1_old.last_shock;
    assign s1_bogus = s1_delta > max_tap_reg;

    assign s1_accel[0] = s1_item_reg.accel_x;
    assign s1_accel[1] = s1_item_reg.accel_y;
    assign s1_accel[2] = s1_item_reg.accel_z;
    assign s1_prev[0]  = s1_old.filt_x;
    assign s1_prev[1]  = s1_old.filt_y;
    assign s1_prev[2]  = s1_old.filt_z;
    assign s3_accel[0] = s3_item_reg.accel_x;
    assign s3_accel[1] = s3_item_reg.accel_y;
    assign s3_accel[2] = s3_item_reg.accel_z;

    for (genvar g = 0; g < 3; g++)
    begin : g_axis
        cmtt_filter u_filter (
            .clk      (clk),
            .adv      (advance),
            .weight   (weight_eff),
            .sample   (s1_accel[g]),
            .prev     (s1_prev[g]),
            .filtered (s3_filt[g])
        );
    end

    // stage 3: motion test and dominant axis
    logic       s3_moving_now;
    logic [2:0] s3_dir;

    always_comb
    begin
        logic signed [8:0] diff;
        logic [8:0]        diff_mag;
        logic [7:0]        mag8;
        logic [6:0]        mag;
        logic [6:0]        max_mag;
        s3_moving_now = 1'b0;
        s3_dir = cmtt_pkg::AXIS_UNKNOWN;
        max_mag = '0;
        for (int k = 0; k < 3; k++)
        begin
            diff = signed'({s3_filt[k][7], s3_filt[k]}) - signed'({s3_accel[k][7], s3_accel[k]});
            diff_mag = diff[8] ? 9'(-diff) : 9'(diff);
            if (diff_mag > {1'b0, thresh_reg})
            begin
                s3_moving_now = 1'b1;
            end
            mag8 = s3_filt[k][7] ? 8'(-s3_filt[k]) : 8'(s3_filt[k]);
            mag = mag8[7] ? 7'h7F : mag8[6:0];
            if (mag > max_mag)
            begin
                s3_dir = {2'(k), s3_filt[k][7]};
                max_mag = mag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_v_reg <= fire && in_range;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_item_reg       <= in_item;
            s2_item_reg       <= s1_item_reg;
            s3_item_reg       <= s2_item_reg;
            s4_item_reg       <= s3_item_reg;
            s2_state_reg      <= s1_old;
            s3_state_reg      <= s2_state_reg;
            s4_state_reg      <= s3_state_reg;
            s2_count_reg      <= s1_delta;
            s3_count_reg      <= s2_count_reg;
            s4_count_reg      <= s3_count_reg;
            s2_bogus_reg      <= s1_bogus;
            s3_bogus_reg      <= s2_bogus_reg;
            s4_bogus_reg      <= s3_bogus_reg;
            s4_filt_reg[0]    <= s3_filt[0];
            s4_filt_reg[1]    <= s3_filt[1];
            s4_filt_reg[2]    <= s3_filt[2];
            s4_moving_now_reg <= s3_moving_now;
            s4_dir_reg        <= s3_dir;
        end
    end

    // stage 4: hysteresis, up axis debounce, results, write-back
    cmtt_pkg::result_t slot [3];
    logic [1:0]        n4;

    always_comb
    begin
        cmtt_pkg::state_t  st;
        cmtt_pkg::result_t cand [5];
        logic [4:0]        flag;
        logic [7:0]        mc;
        logic [7:0]        cc;
        logic [2:0]        cax;
        logic [2:0]        rax;
        logic              dir_changed;
        logic              up_first;
        logic              moved;
        logic              stop_ev;
        logic              up_second;
        logic              mv;
        st = s4_state_reg;
        mc = st.motion_cnt;
        cc = st.cand_cnt;
        cax = st.cand_axis;
        rax = st.rep_axis;
        up_first = 1'b0;
        up_second = 1'b0;
        mv = st.moving;

        if (s4_moving_now_reg)
        begin
            if ((!st.moving || mc < stop_reg) && mc != 8'hFF)
            begin
                mc = mc + 8'd1;
            end
        end
        else if (mc != 8'd0)
        begin
            mc = mc - 8'd1;
        end

        dir_changed = st.prev_axis != cmtt_pkg::AXIS_UNKNOWN && st.prev_axis != s4_dir_reg;

        if (s4_dir_reg == cax)
        begin
            if (cax != rax)
            begin
                if (cc != 8'hFF)
                begin
                    cc = cc + 8'd1;
                end
                if (cc >= stable_reg)
                begin
                    up_first = 1'b1;
                    rax = cax;
                end
            end
            else
            begin
                cc = 8'd0;
            end
        end
        else
        begin
            cc = 8'd0;
            cax = s4_dir_reg;
        end

        moved = dir_changed || (mc >= start_reg && !st.moving);
        stop_ev = !moved && mc == 8'd0 && st.moving;
        if (stop_ev && cax != rax)
        begin
            up_second = 1'b1;
            rax = cax;
        end
        if (moved)
        begin
            mv = 1'b1;
            mc = stop_reg;
        end
        else if (stop_ev)
        begin
            mv = 1'b0;
        end

        wb_state = st;
        wb_state.last_shock = s4_item_reg.shock_total;
        if (!s4_bogus_reg)
        begin
            wb_state.filt_x     = s4_filt_reg[0];
            wb_state.filt_y     = s4_filt_reg[1];
            wb_state.filt_z     = s4_filt_reg[2];
            wb_state.motion_cnt = mc;
            wb_state.moving     = mv;
            wb_state.prev_axis  = s4_dir_reg;
            wb_state.rep_axis   = rax;
            wb_state.cand_axis  = cax;
            wb_state.cand_cnt   = cc;
        end

        cand[0] = cmtt_pkg::base_result(cmtt_pkg::KIND_TAPPED, s4_item_reg);
        cand[0].tap_count        = s4_count_reg;
        cand[0].tap_duration_out = s4_item_reg.tap_duration;
        cand[0].tap_negative_out = s4_item_reg.tap_negative;
        cand[0].tap_positive_out = s4_item_reg.tap_positive;
        cand[1] = cmtt_pkg::base_result(cmtt_pkg::KIND_UP_AXIS, s4_item_reg);
        cand[1].axis = st.cand_axis;
        cand[2] = cmtt_pkg::base_result(cmtt_pkg::KIND_MOVED, s4_item_reg);
        cand[2].axis    = s4_dir_reg;
        cand[2].moved_x = s4_item_reg.accel_x;
        cand[2].moved_y = s4_item_reg.accel_y;
        cand[2].moved_z = s4_item_reg.accel_z;
        cand[3] = cmtt_pkg::base_result(cmtt_pkg::KIND_UP_AXIS, s4_item_reg);
        cand[3].axis = cax;
        cand[4] = cmtt_pkg::base_result(cmtt_pkg::KIND_STOPPED, s4_item_reg);

        flag = {stop_ev, up_second, moved, up_first, s4_count_reg != 8'd0};
        if (s4_bogus_reg || !s4_v_reg)
        begin
            flag = '0;
        end

        // pack results in order into the slots
        slot[0] = cand[0];
        slot[1] = cand[0];
        slot[2] = cand[0];
        n4 = 2'd0;
        for (int k = 0; k < 5; k++)
        begin
            if (flag[k] && n4 != 2'd3)
            begin
                slot[n4] = cand[k];
                n4 = n4 + 2'd1;
            end
        end
        if (n4 != 2'd0)
        begin
            slot[n4 - 2'd1].last = 1'b1;
        end
    end

    // result buffer
    cmtt_pkg::result_t res_reg [3];
    cmtt_pkg::result_t out_res;
    logic [1:0]        cnt_reg;
    logic [1:0]        ptr_reg;
    logic              pop;
    logic              can_take;
    logic              load;

    assign pop      = result.valid && result.ready;
    assign can_take = cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop);
    assign advance  = !s4_v_reg || n4 == 2'd0 || can_take;
    assign load     = advance && s4_v_reg && n4 != 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            ptr_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= n4;
            ptr_reg <= 2'd0;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
            ptr_reg <= ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg[0] <= slot[0];
            res_reg[1] <= slot[1];
            res_reg[2] <= slot[2];
        end
    end

    assign out_res                 = res_reg[ptr_reg];
    assign result.valid            = cnt_reg != 2'd0;
    assign result.kind             = out_res.kind;
    assign result.cube_out         = out_res.cube_out;
    assign result.stamp_ms         = out_res.stamp_ms;
    assign result.tap_count        = out_res.tap_count;
    assign result.tap_duration_out = out_res.tap_duration_out;
    assign result.tap_negative_out = out_res.tap_negative_out;
    assign result.tap_positive_out = out_res.tap_positive_out;
    assign result.axis             = out_res.axis;
    assign result.moved_x          = out_res.moved_x;
    assign result.moved_y          = out_res.moved_y;
    assign result.moved_z          = out_res.moved_z;
    assign result.last             = out_res.last;

    // checks
    a_no_overlap_s1_s2: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_v_reg && s2_v_reg) |-> (s1_item_reg.cube_index != s2_item_reg.cube_index))
        else $error("two requests for one cube overlap in the pipeline");

    a_no_overlap_s1_s4: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_v_reg && s4_v_reg) |-> (s1_item_reg.cube_index != s4_item_reg.cube_index))
        else $error("read of a cube overlaps its write-back");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop)))
        else $error("result buffer overwritten while results pending");

    a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && cnt_reg == 2'd1) |-> result.last)
        else $error("final buffered result lacks last");

    a_bogus_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_v_reg && s4_bogus_reg) |-> (n4 == 2'd0))
        else $error("discarded report produced a result");

endmodule

`default_nettype wire
